>>> rtl/core/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and helpers of the printable string extractor:
// item structs, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package pse_pkg;

  // default sizes
  localparam int DEF_MAX_MIN_LEN = 64;
  localparam int DEF_MAX_RUN     = 1022;
  localparam int DEF_OFFSET_BITS = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_MIN_LEN       = 1'b0;
  localparam logic REG_IDX_PRINT_OFFSETS = 1'b1;
  localparam logic [6:0] MIN_LEN_RESET   = 7'd4;

  // character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } pse_in_t;

  // result item
  typedef struct packed {
    logic [7:0]  char_out;
    logic [31:0] string_offset;
    logic        end_of_string;
  } pse_out_t;

  // what an incoming item needs from the controller
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_DIRECT,
    KIND_REPLAY
  } pse_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_LAST
  } pse_state_t;

  typedef struct packed {
    pse_kind_t kind;
    logic      rd_last;
    logic      out_free;
  } pse_status_t;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic rd_clear;
    logic rd_issue;
    logic load_ram;
    logic load_held;
  } pse_cmd_t;

  function automatic logic is_printable(input logic [7:0] b);
    is_printable = (b >= CH_SPACE && b < CH_DEL) || b == CH_BS || b == CH_TAB ||
                   b == CH_FF;
  endfunction

endpackage

>>> rtl/core/pse_ram.sv
// ----------------------------------------------------------------------------
// pse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Run tracking, position counters, prefix buffer RAM and the output
// register of the printable string extractor.
// ----------------------------------------------------------------------------
module pse_datapath #(
  parameter int MAX_MIN_LEN = 64,
  parameter int MAX_RUN     = 1022,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [6:0]           min_len,
  input  logic                 print_offsets,
  input  pse_pkg::pse_in_t     byte_item,
  input  pse_pkg::pse_cmd_t    cmd,
  output pse_pkg::pse_status_t status,
  output logic                 str_valid,
  input  logic                 str_ready,
  output pse_pkg::pse_out_t    str_item
);
  import pse_pkg::*;

  localparam int AW  = (MAX_MIN_LEN > 1) ? $clog2(MAX_MIN_LEN) : 1;
  localparam int MLW = $clog2(MAX_MIN_LEN + 1);
  localparam int RLW = $clog2(MAX_RUN + 1);
  localparam int OW  = OFFSET_BITS;

  logic [RLW-1:0] run_length;
  logic [OW-1:0]  byte_position;
  logic [OW-1:0]  run_start;
  logic [7:0]     held_byte;
  logic [AW-1:0]  rd_idx;

  logic [MLW-1:0] min_eff;
  logic [MLW-1:0] last_idx;
  logic [RLW-1:0] m_ext;
  logic [RLW-1:0] rl_inc;
  logic           is_close;
  logic           at_max;
  logic           ram_we;
  logic [7:0]     ram_rdata;
  logic [OW-1:0]  start_eff;
  logic [OW+31:0] ext_direct;
  logic [OW+31:0] ext_run;
  logic [31:0]    off_direct;
  logic [31:0]    off_run;

  // effective minimum length, clamped to 1..MAX_MIN_LEN
  always_comb begin
    if (min_len == 7'd0) begin
      min_eff = MLW'(1);
    end else if (min_len > 7'(MAX_MIN_LEN)) begin
      min_eff = MLW'(MAX_MIN_LEN);
    end else begin
      min_eff = MLW'(min_len);
    end
  end

  assign m_ext    = RLW'(min_eff);
  assign last_idx = min_eff - MLW'(2);
  assign rl_inc   = run_length + 1'b1;
  assign at_max   = run_length >= RLW'(MAX_RUN);
  assign is_close = byte_item.stream_end || !is_printable(byte_item.data_byte);

  // classify the waiting item, replay and output status
  always_comb begin
    if (is_close) begin
      status.kind = (run_length != '0 && run_length >= m_ext) ? KIND_DIRECT : KIND_NONE;
    end else if (at_max || rl_inc < m_ext) begin
      status.kind = KIND_NONE;
    end else if (rl_inc == m_ext && min_eff != MLW'(1)) begin
      status.kind = KIND_REPLAY;
    end else begin
      status.kind = KIND_DIRECT;
    end
    status.rd_last  = rd_idx == AW'(last_idx);
    status.out_free = !str_valid || str_ready;
  end

  // run state and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      run_length    <= '0;
      byte_position <= '0;
      run_start     <= '0;
    end else if (cmd.accept) begin
      if (is_close) begin
        run_length    <= '0;
        byte_position <= byte_item.stream_end ? '0 : byte_position + 1'b1;
      end else begin
        if (run_length == '0) begin
          run_start <= byte_position;
        end
        byte_position <= byte_position + 1'b1;
        if (!at_max) begin
          run_length <= rl_inc;
        end
      end
    end
  end

  // held byte and replay read index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      held_byte <= byte_item.data_byte;
    end
    if (cmd.rd_clear) begin
      rd_idx <= '0;
    end else if (cmd.load_ram) begin
      rd_idx <= rd_idx + 1'b1;
    end
  end

  // prefix buffer: bytes of a run still shorter than min_len
  assign ram_we = cmd.accept && !is_close && !at_max && (rl_inc < m_ext);

  pse_ram #(
    .WIDTH(8),
    .DEPTH(MAX_MIN_LEN)
  ) u_prefix_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(run_length[AW-1:0]),
    .wdata(byte_item.data_byte),
    .re   (cmd.rd_issue),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  // reported offsets; a run opening on this item starts here
  assign start_eff  = (!is_close && run_length == '0) ? byte_position : run_start;
  assign ext_direct = {32'b0, start_eff};
  assign ext_run    = {32'b0, run_start};
  assign off_direct = print_offsets ? ext_direct[31:0] : 32'd0;
  assign off_run    = print_offsets ? ext_run[31:0] : 32'd0;

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      str_valid <= 1'b0;
    end else if (cmd.load_direct || cmd.load_ram || cmd.load_held) begin
      str_valid <= 1'b1;
    end else if (str_ready) begin
      str_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_direct) begin
      str_item.char_out      <= is_close ? 8'd0 : byte_item.data_byte;
      str_item.string_offset <= off_direct;
      str_item.end_of_string <= is_close;
    end else if (cmd.load_ram) begin
      str_item.char_out      <= ram_rdata;
      str_item.string_offset <= off_run;
      str_item.end_of_string <= 1'b0;
    end else if (cmd.load_held) begin
      str_item.char_out      <= held_byte;
      str_item.string_offset <= off_run;
      str_item.end_of_string <= 1'b0;
    end
  end

endmodule

>>> rtl/core/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Controller of the printable string extractor: takes items, and steps
// the prefix replay through the buffer RAM into the output register.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  pse_pkg::pse_status_t status,
  output pse_pkg::pse_cmd_t    cmd
);
  import pse_pkg::*;

  pse_state_t state;
  pse_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    byte_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        byte_ready = status.out_free;
        if (byte_valid && status.out_free) begin
          cmd.accept = 1'b1;
          unique case (status.kind)
            KIND_DIRECT: cmd.load_direct = 1'b1;
            KIND_REPLAY: begin
              cmd.rd_clear = 1'b1;
              state_next   = ST_RD_ISSUE;
            end
            KIND_NONE: ;
            default: ;
          endcase
        end
      end
      ST_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (status.out_free) begin
          cmd.load_ram = 1'b1;
          state_next   = status.rd_last ? ST_LAST : ST_RD_ISSUE;
        end
      end
      ST_LAST: begin
        if (status.out_free) begin
          cmd.load_held = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/printable_string_extractor_unit.sv
// ----------------------------------------------------------------------------
// printable_string_extractor_unit
// Finds runs of printable bytes in a byte stream and reports those of at
// least min_len bytes, character by character, then an end-of-string item.
//
//   channel   direction  handshake                  payload
//   byte      in         byte_valid / byte_ready    byte_item (pse_in_t)
//   str       out        str_valid / str_ready      str_item (pse_out_t)
//   config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A byte that yields no item or a single item is taken directly, with no replay.
// The byte that brings a run to min_len starts a replay: each buffered byte
// is read from the prefix RAM and then loaded into the output register.
// Reset (rst, synchronous) clears run state, position counters and the output
// valid flag; the prefix RAM and the output payload are not cleared.
// byte_ready is low while the output register holds an untaken item or
// a replay is in progress.
// ----------------------------------------------------------------------------
module printable_string_extractor_unit #(
  parameter int MAX_MIN_LEN = pse_pkg::DEF_MAX_MIN_LEN,
  parameter int MAX_RUN     = pse_pkg::DEF_MAX_RUN,
  parameter int OFFSET_BITS = pse_pkg::DEF_OFFSET_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  pse_pkg::pse_in_t                byte_item,
  output logic                            str_valid,
  input  logic                            str_ready,
  output pse_pkg::pse_out_t               str_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pse_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pse_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pse_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import pse_pkg::*;

  logic [6:0]  min_len;
  logic        print_offsets;
  logic        cfg_write;
  pse_status_t status;
  pse_cmd_t    cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_len       <= MIN_LEN_RESET;
      print_offsets <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_IDX_MIN_LEN:       min_len       <= pwdata[6:0];
        REG_IDX_PRINT_OFFSETS: print_offsets <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      REG_IDX_MIN_LEN:       prdata = {25'd0, min_len};
      REG_IDX_PRINT_OFFSETS: prdata = {31'd0, print_offsets};
      default:               prdata = '0;
    endcase
  end

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pse_datapath #(
    .MAX_MIN_LEN(MAX_MIN_LEN),
    .MAX_RUN    (MAX_RUN),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .min_len      (min_len),
    .print_offsets(print_offsets),
    .byte_item    (byte_item),
    .cmd          (cmd),
    .status       (status),
    .str_valid    (str_valid),
    .str_ready    (str_ready),
    .str_item     (str_item)
  );

endmodule

>>> rtl/core/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks of the printable string extractor, bound to the top.
// ----------------------------------------------------------------------------
module pse_checker (
  input logic              clk,
  input logic              rst,
  input logic              str_valid,
  input logic              str_ready,
  input pse_pkg::pse_out_t str_item
);
  import pse_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    str_valid && !str_ready |=> str_valid && $stable(str_item))
    else $error("result item changed while stalled");

  // closing item carries no character
  a_eos_zero: assert property (@(posedge clk) disable iff (rst)
    str_valid && str_item.end_of_string |-> str_item.char_out == 8'd0)
    else $error("end-of-string item with nonzero character");

  // character items carry only printable bytes
  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    str_valid && !str_item.end_of_string |-> is_printable(str_item.char_out))
    else $error("non-printable byte reported");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !str_valid)
    else $error("result item valid after reset");

endmodule

bind printable_string_extractor_unit pse_checker u_pse_checker (
  .clk      (clk),
  .rst      (rst),
  .str_valid(str_valid),
  .str_ready(str_ready),
  .str_item (str_item)
);

>>> tb/printable_string_extractor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// printable_string_extractor_unit_tb
// Self-checking bench for the printable string extractor. Byte items go in
// over valid/ready with random gaps. A scoreboard model predicts every string
// item: character, run offset and end marker. A checker compares each item
// the block hands out against the oldest prediction. Configuration is written
// over the register port only while the block is drained.
// ----------------------------------------------------------------------------
module printable_string_extractor_unit_tb;
  import pse_pkg::*;

  localparam int MAX_MIN_LEN  = DEF_MAX_MIN_LEN;
  localparam int MAX_RUN      = DEF_MAX_RUN;
  localparam int DRAIN_CYCLES = 2 * MAX_MIN_LEN + 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  byte_valid = 1'b0;
  logic                  byte_ready;
  pse_in_t               byte_item  = '0;
  logic                  str_valid;
  logic                  str_ready  = 1'b0;
  pse_out_t              str_item;
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [CFG_DATA_W-1:0] pwdata     = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // scoreboard copy of the block's configuration and run state
  logic [6:0]  cfg_min_len = MIN_LEN_RESET;
  logic        cfg_offsets = 1'b0;
  logic [7:0]  prefix_mem [MAX_MIN_LEN];
  int unsigned run_len     = 0;
  logic [31:0] stream_pos  = '0;
  logic [31:0] run_origin  = '0;
  pse_out_t    str_expect_q [$];
  pse_out_t    str_want;

  // run control and statistics
  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int ready_gap = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int chars_checked = 0;
  int strings_closed = 0;

  printable_string_extractor_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .str_valid  (str_valid),
    .str_ready  (str_ready),
    .str_item   (str_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // printable set: 0x20..0x7e plus backspace, tab and form feed
  function automatic logic text_byte(input logic [7:0] b);
    return (b >= CH_SPACE && b < CH_DEL) || b == CH_BS || b == CH_TAB || b == CH_FF;
  endfunction

  function automatic void queue_str_item(input logic [7:0] ch, input logic eos);
    pse_out_t r;
    r.char_out      = ch;
    r.string_offset = cfg_offsets ? run_origin : 32'd0;
    r.end_of_string = eos;
    str_expect_q.push_back(r);
  endfunction

  // advance the scoreboard by one accepted byte item
  function automatic void predict_strings(input pse_in_t it);
    int unsigned thresh;
    thresh = (cfg_min_len == 0) ? 1 :
             (cfg_min_len > MAX_MIN_LEN) ? MAX_MIN_LEN : cfg_min_len;
    if (it.stream_end || !text_byte(it.data_byte)) begin
      // run closes; only a reported run gets an end item
      if (run_len > 0 && run_len >= thresh) queue_str_item(8'h00, 1'b1);
      run_len    = 0;
      stream_pos = it.stream_end ? 32'd0 : stream_pos + 32'd1;
    end else begin
      if (run_len == 0) run_origin = stream_pos;
      stream_pos = stream_pos + 32'd1;
      // bytes past the run limit are counted but dropped
      if (run_len < MAX_RUN) begin
        run_len++;
        if (run_len < thresh) begin
          prefix_mem[(run_len - 1) % MAX_MIN_LEN] = it.data_byte;
        end else begin
          // threshold reached: replay the held prefix first
          if (run_len == thresh) begin
            for (int i = 0; i + 1 < thresh; i++) queue_str_item(prefix_mem[i % MAX_MIN_LEN], 1'b0);
          end
          queue_str_item(it.data_byte, 1'b0);
        end
      end
    end
  endfunction

  function automatic logic [7:0] pick_printable();
    case ($urandom_range(0, 19))
      0: return CH_BS;
      1: return CH_TAB;
      2: return CH_FF;
      default: return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
    endcase
  endfunction

  function automatic logic [7:0] pick_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (text_byte(b));
    return b;
  endfunction

  // offer one byte item and wait until it is taken
  task automatic send_byte(input logic [7:0] data, input logic end_mark);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    byte_item  <= '{data_byte: data, stream_end: end_mark};
    byte_valid <= 1'b1;
    do @(posedge clk); while (!byte_ready);
    predict_strings(byte_item);
    bytes_sent++;
  endtask

  task automatic send_run(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_printable(), 1'b0);
  endtask

  task automatic close_run(input bit use_end);
    if (use_end) send_byte(8'($urandom_range(0, 255)), 1'b1);
    else send_byte(pick_other(), 1'b0);
  endtask

  // stop offering, let every predicted item arrive, then let a replay settle
  task automatic wait_drained();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (str_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_IDX_MIN_LEN:       cfg_min_len = value[6:0];
      REG_IDX_PRINT_OFFSETS: cfg_offsets = value[0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [6:0] min_len, input logic offsets);
    wait_drained();
    write_reg(REG_IDX_MIN_LEN, 32'(min_len));
    write_reg(REG_IDX_PRINT_OFFSETS, 32'(offsets));
  endtask

  // reset settings: short run, printable edges, special bytes, idle stream end
  task automatic test_reset_defaults();
    logic [8:0] seq [19] = '{9'h000, 9'h0FF, 9'h061, 9'h062, 9'h063, 9'h07F, 9'h01F,
                             9'h020, 9'h07E, 9'h008, 9'h009, 9'h00C, 9'h1A5, 9'h100,
                             9'h051, 9'h052, 9'h053, 9'h054, 9'h00A};
    foreach (seq[i]) send_byte(seq[i][7:0], seq[i][8]);
  endtask

  // threshold above the maximum saturates to the largest one, offsets on;
  // also writes 63 of the 64 prefix store entries
  task automatic test_threshold_extremes();
    set_config(7'd127, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h0D, 1'b0);
    send_run(65);
    send_byte(8'hC3, 1'b1);
    // zero acts as one, one reports every single printable byte
    set_config(7'd0, 1'b1);
    send_run(3);
    send_byte(8'h1B, 1'b0);
    send_run(1);
    send_byte(8'h5A, 1'b1);
    set_config(7'd1, 1'b0);
    send_run(2);
    send_byte(8'hFE, 1'b0);
  endtask

  // threshold moved while a run is open, before and after it qualified
  task automatic test_min_len_mid_run();
    set_config(7'd8, 1'b1);
    send_byte(8'h07, 1'b0);
    send_run(5);
    wait_drained();
    write_reg(REG_IDX_MIN_LEN, 32'd3);
    send_run(3);
    wait_drained();
    write_reg(REG_IDX_MIN_LEN, 32'd10);
    send_run(5);
    close_run(1'b0);
  endtask

  // receiver holds off while the sender keeps pushing a long string
  task automatic test_output_hold();
    set_config(7'd4, 1'b1);
    hold_req++;
    send_run(16);
    close_run(1'b1);
  endtask

  // mostly well-formed runs near the threshold, some noise bytes
  task automatic test_random_phases(input int phases, input int items_per_phase);
    int sent;
    int run_n;
    int thresh;
    for (int p = 0; p < phases; p++) begin
      thresh = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_MIN_LEN) :
                                             $urandom_range(1, 8);
      set_config(7'(thresh), 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < items_per_phase) begin
        if ($urandom_range(0, 9) < 7) begin
          run_n = $urandom_range(1, thresh + 4);
          send_run(run_n);
          // sometimes move the threshold under the open run
          if ($urandom_range(0, 5) == 0) begin
            wait_drained();
            write_reg(REG_IDX_MIN_LEN, 32'($urandom_range(1, 8)));
            send_run(3);
            run_n += 3;
          end
          close_run($urandom_range(0, 3) == 0);
          sent += run_n + 1;
        end else begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
          sent++;
        end
      end
    end
  endtask

  // receiver: random stall bursts plus one long requested hold-off
  always @(negedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_left <= HOLD_CYCLES - 1;
      str_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      str_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      str_ready <= 1'b0;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      ready_gap <= $urandom_range(1, 10) - 1;
      str_ready <= 1'b0;
    end else begin
      str_ready <= 1'b1;
    end
  end

  // compare each string item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && str_valid && str_ready) begin
      if (str_expect_q.size() == 0) begin
        $display("%0t: unexpected item char=%h offset=%h eos=%b", $time,
                 str_item.char_out, str_item.string_offset, str_item.end_of_string);
        mismatches++;
      end else begin
        str_want = str_expect_q.pop_front();
        if (str_item.char_out !== str_want.char_out) begin
          $display("%0t: char_out expected %h actual %h", $time,
                   str_want.char_out, str_item.char_out);
          mismatches++;
        end
        if (str_item.string_offset !== str_want.string_offset) begin
          $display("%0t: string_offset expected %h actual %h", $time,
                   str_want.string_offset, str_item.string_offset);
          mismatches++;
        end
        if (str_item.end_of_string !== str_want.end_of_string) begin
          $display("%0t: end_of_string expected %b actual %b", $time,
                   str_want.end_of_string, str_item.end_of_string);
          mismatches++;
        end
        if (str_want.end_of_string) strings_closed++;
        else chars_checked++;
      end
    end
  end

  // watchdog on cycles with no handshake on any port
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (str_valid && str_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d items still expected", $time,
                 STALL_LIMIT, str_expect_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_threshold_extremes();
    test_min_len_mid_run();
    test_output_hold();
    test_random_phases(2, 20);

    // closing stretch with both sides streaming
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    test_random_phases(1, 20);
    wait_drained();

    $display("checked %0d string characters and %0d string ends from %0d bytes",
             chars_checked, strings_closed, bytes_sent);
    $display("thresholds 0 to 127, offsets on and off, threshold moves, output hold-off");
    if (mismatches == 0 && str_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pse_pkg.sv
rtl/core/pse_ram.sv
rtl/core/pse_datapath.sv
rtl/core/pse_ctrl.sv
rtl/core/printable_string_extractor_unit.sv
rtl/core/pse_checker.sv
tb/printable_string_extractor_unit_tb.sv
